FILE: design/pnss_pkg.sv
`default_nettype none
package pnss_pkg;

	localparam int MAX_CHARS = 1024;
	localparam int CHAR_W    = 16;
	localparam int REQ_W     = 2;
	localparam int CUR_W     = 11;
	localparam int SPAN_W    = 10;
	localparam int IDX_W     = $clog2(MAX_CHARS + 1);
	localparam int ADDR_W    = $clog2(MAX_CHARS);
	localparam int WORK_W    = (IDX_W > CUR_W) ? IDX_W : CUR_W;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [REQ_W-1:0]  req_t;
	typedef logic [CUR_W-1:0]  cur_t;
	typedef logic [SPAN_W-1:0] span_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam req_t REQ_LOAD  = 2'd0;
	localparam req_t REQ_LEFT  = 2'd1;
	localparam req_t REQ_RIGHT = 2'd2;

	localparam char_t CH_DIG_BELOW = 16'd47;
	localparam char_t CH_DIG_ABOVE = 16'd58;
	localparam char_t CH_SPACE     = 16'h0020;
	localparam char_t CH_NBSP      = 16'h00A0;
	localparam char_t CH_LPAR      = 16'h0028;
	localparam char_t CH_RPAR      = 16'h0029;
	localparam char_t CH_PLUS      = 16'h002B;
	localparam char_t CH_STAR      = 16'h002A;
	localparam char_t CH_DASH      = 16'h002D;
	localparam char_t CH_HASH      = 16'h0023;
	localparam char_t CH_SLASH     = 16'h002F;
	localparam char_t CH_DOT       = 16'h002E;

	typedef struct packed {
		logic  en;
		addr_t addr;
		char_t data;
	} pnss_wr_t;

	typedef struct packed {
		logic  found;
		span_t span_start;
		span_t span_end;
	} pnss_res_t;

	function automatic logic is_digit(char_t c);
		return (c > CH_DIG_BELOW) && (c < CH_DIG_ABOVE);
	endfunction

	// prefix characters are a subset of the delimiters
	function automatic logic is_delim(char_t c);
		return (c == CH_SPACE) || (c == CH_NBSP) || (c == CH_LPAR) ||
			(c == CH_RPAR) || (c == CH_PLUS) || (c == CH_STAR) ||
			(c == CH_DASH) || (c == CH_HASH) || (c == CH_SLASH) || (c == CH_DOT);
	endfunction

endpackage
`default_nettype wire

FILE: design/pnss_char_mem.sv
`default_nettype none
module pnss_char_mem (
	input  wire logic             clk,
	input  wire pnss_pkg::pnss_wr_t wr,
	input  wire pnss_pkg::addr_t  rd_addr,
	output pnss_pkg::char_t       rd_data
);
	import pnss_pkg::*;

	char_t mem_q [MAX_CHARS];
	char_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: design/pnss_scan_seq.sv
`default_nettype none
module pnss_scan_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire pnss_pkg::req_t    req_type,
	input  wire pnss_pkg::char_t   char_code,
	input  wire logic              starts_string,
	input  wire pnss_pkg::cur_t    cursor_pos,
	input  wire logic              out_free,
	output logic                   busy,
	output logic                   done,
	output pnss_pkg::pnss_res_t    result,
	output pnss_pkg::pnss_wr_t     wr,
	output pnss_pkg::addr_t        rd_addr,
	input  wire pnss_pkg::char_t   rd_data
);
	import pnss_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LW_RD = 4'd1;
	localparam logic [3:0] S_LW_EV = 4'd2;
	localparam logic [3:0] S_LT_RD = 4'd3;
	localparam logic [3:0] S_LT_EV = 4'd4;
	localparam logic [3:0] S_HT_RD = 4'd5;
	localparam logic [3:0] S_HT_EV = 4'd6;
	localparam logic [3:0] S_RW_RD = 4'd7;
	localparam logic [3:0] S_RW_EV = 4'd8;
	localparam logic [3:0] S_RT_RD = 4'd9;
	localparam logic [3:0] S_RT_EV = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0]       state_q, state_n;
	logic [IDX_W-1:0] len_q, len_n;
	logic [WORK_W-1:0] cur_q, cur_n;
	logic [WORK_W-1:0] cm1_q, cm1_n;
	logic [WORK_W-1:0] lo_q, lo_n;
	logic [WORK_W-1:0] hi_q, hi_n;
	logic [WORK_W-1:0] first_q, first_n;
	logic             first_v_q, first_v_n;
	logic             got_q, got_n;
	pnss_res_t        res_q, res_n;

	logic              sel_hi, dec;
	logic [WORK_W-1:0] idx, step, len_w, cursor_w;
	logic              in_range, dig, vld;
	char_t             c;
	logic [IDX_W-1:0]  base;
	logic              walk_end, left_done;

	// shared index unit: one adder steps whichever pointer is live
	assign sel_hi = (state_q == S_HT_RD) || (state_q == S_HT_EV) ||
		(state_q == S_RW_RD) || (state_q == S_RW_EV) ||
		(state_q == S_RT_RD) || (state_q == S_RT_EV);
	assign dec = (state_q == S_LW_EV) || (state_q == S_HT_EV) || (state_q == S_RT_EV);
	assign idx = sel_hi ? hi_q : lo_q;
	assign step = idx + (dec ? {WORK_W{1'b1}} : WORK_W'(1));

	assign len_w    = WORK_W'(len_q);
	assign cursor_w = WORK_W'(cursor_pos);
	assign in_range = idx < len_w;
	assign c        = in_range ? rd_data : '0;
	assign dig      = is_digit(c);
	assign vld      = dig || is_delim(c);
	assign rd_addr  = idx[ADDR_W-1:0];
	assign base     = starts_string ? '0 : len_q;

	always_comb begin
		state_n   = state_q;
		len_n     = len_q;
		cur_n     = cur_q;
		cm1_n     = cm1_q;
		lo_n      = lo_q;
		hi_n      = hi_q;
		first_n   = first_q;
		first_v_n = first_v_q;
		got_n     = got_q;
		res_n     = res_q;
		walk_end  = 1'b0;
		left_done = 1'b0;
		done      = 1'b0;
		wr.en     = 1'b0;
		wr.addr   = base[ADDR_W-1:0];
		wr.data   = char_code;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cur_n     = cursor_w;
					cm1_n     = cursor_w - WORK_W'(1);
					lo_n      = cursor_w - WORK_W'(1);
					hi_n      = cursor_w;
					first_v_n = 1'b0;
					got_n     = 1'b0;
					unique case (req_type)
						REQ_LOAD: begin
							if (base < IDX_W'(MAX_CHARS)) begin
								wr.en = 1'b1;
								len_n = base + IDX_W'(1);
							end else begin
								len_n = base;
							end
						end
						REQ_LEFT: begin
							if ((cursor_w == '0) || (cursor_w > len_w)) begin
								res_n   = '0;
								state_n = S_OUT;
							end else begin
								state_n = S_LW_RD;
							end
						end
						REQ_RIGHT: begin
							if (cursor_w >= len_w) begin
								res_n   = '0;
								state_n = S_OUT;
							end else begin
								state_n = S_RW_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_LW_RD: state_n = S_LW_EV;
			S_LW_EV: begin
				if (vld) begin
					if (!first_v_q) begin
						first_n   = lo_q;
						first_v_n = 1'b1;
					end
					if (dig) got_n = 1'b1;
					if (lo_q == '0) begin
						// ran off the start; index 0 is valid, so it counts
						walk_end = 1'b1;
						got_n    = 1'b1;
					end else begin
						lo_n    = step;
						state_n = S_LW_RD;
					end
				end else if (got_q) begin
					walk_end = 1'b1;
				end else if ((lo_q == cm1_q) && (lo_q != '0)) begin
					// one stray character allowed right at the cursor
					lo_n    = step;
					state_n = S_LW_RD;
				end else begin
					walk_end = 1'b1;
				end
				if (walk_end) begin
					if (!got_n) begin
						res_n   = '0;
						state_n = S_OUT;
					end else begin
						hi_n    = first_v_n ? first_n : cm1_q;
						state_n = S_LT_RD;
					end
				end
			end
			S_LT_RD: state_n = S_LT_EV;
			S_LT_EV: begin
				if (!vld) begin
					lo_n = step;
				end
				if (!vld && (step < cur_q)) begin
					state_n = S_LT_RD;
				end else if (hi_q > lo_n) begin
					state_n = S_HT_RD;
				end else begin
					left_done = 1'b1;
				end
			end
			S_HT_RD: state_n = S_HT_EV;
			S_HT_EV: begin
				if (!vld) begin
					hi_n = step;
				end
				if (!vld && (step > lo_q)) begin
					state_n = S_HT_RD;
				end else begin
					left_done = 1'b1;
				end
			end
			S_RW_RD: state_n = S_RW_EV;
			S_RW_EV: begin
				if (vld) begin
					if (dig) got_n = 1'b1;
					hi_n    = step;
					state_n = (step < len_w) ? S_RW_RD : S_RT_RD;
				end else begin
					state_n = S_RT_RD;
				end
			end
			S_RT_RD: state_n = S_RT_EV;
			S_RT_EV: begin
				if (dig) begin
					res_n.found      = 1'b1;
					res_n.span_start = cur_q[SPAN_W-1:0];
					res_n.span_end   = hi_q[SPAN_W-1:0];
					state_n          = S_OUT;
				end else if (hi_q == cur_q) begin
					res_n   = '0;
					state_n = S_OUT;
				end else begin
					hi_n    = step;
					state_n = S_RT_RD;
				end
			end
			S_OUT: begin
				if (out_free) begin
					done    = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase

		if (left_done) begin
			res_n.found      = 1'b1;
			res_n.span_start = lo_n[SPAN_W-1:0];
			res_n.span_end   = hi_n[SPAN_W-1:0];
			state_n          = S_OUT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
		end else begin
			state_q <= state_n;
			len_q   <= len_n;
		end
	end

	always_ff @(posedge clk) begin
		cur_q     <= cur_n;
		cm1_q     <= cm1_n;
		lo_q      <= lo_n;
		hi_q      <= hi_n;
		first_q   <= first_n;
		first_v_q <= first_v_n;
		got_q     <= got_n;
		res_q     <= res_n;
	end

	assign busy   = (state_q != S_IDLE);
	assign result = res_q;

endmodule
`default_nettype wire

FILE: design/phone_number_span_scanner.sv
`default_nettype none
// Phone number span scanner. A load transfer (req_type 0) appends one 16-bit
// character to a 1024-entry buffer; starts_string empties the buffer first and
// characters past capacity are dropped. A search transfer (1 = left of
// cursor_pos, 2 = right of it) returns one result: found and the first and last
// index of the candidate span, both 0 when nothing is found. Loads give no
// result. Searches run on one index stepper against the buffer's single
// registered read port, with a read state and an evaluate state per character
// examined. req_stall is high for the whole search; loads are taken back to
// back, also while a result waits on res_stall.
module phone_number_span_scanner (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire pnss_pkg::req_t    req_type,
	input  wire pnss_pkg::char_t   char_code,
	input  wire logic              starts_string,
	input  wire pnss_pkg::cur_t    cursor_pos,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic                   found,
	output pnss_pkg::span_t        span_start,
	output pnss_pkg::span_t        span_end
);
	import pnss_pkg::*;

	logic      busy, done, start, out_free;
	pnss_res_t result;
	pnss_wr_t  wr;
	addr_t     rd_addr;
	char_t     rd_data;
	logic      res_valid_q;
	pnss_res_t res_q;

	assign req_stall = busy;
	assign start     = req_valid && !busy;
	assign out_free  = !res_valid_q || !res_stall;

	pnss_scan_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.req_type      (req_type),
		.char_code     (char_code),
		.starts_string (starts_string),
		.cursor_pos    (cursor_pos),
		.out_free      (out_free),
		.busy          (busy),
		.done          (done),
		.result        (result),
		.wr            (wr),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data)
	);

	pnss_char_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= result;
		end
	end

	assign res_valid  = res_valid_q;
	assign found      = res_q.found;
	assign span_start = res_q.span_start;
	assign span_end   = res_q.span_end;

endmodule
`default_nettype wire

FILE: design/pnss_checker.sv
`default_nettype none
module pnss_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            req_valid,
	input wire logic            req_stall,
	input wire pnss_pkg::req_t  req_type,
	input wire logic            res_valid,
	input wire logic            res_stall,
	input wire logic            found,
	input wire pnss_pkg::span_t span_start,
	input wire pnss_pkg::span_t span_end
);
	import pnss_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable({found, span_start, span_end}))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !found |-> (span_start == '0) && (span_end == '0))
		else $error("miss with non-zero span");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && found |-> span_start <= span_end)
		else $error("span start beyond span end");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && ((req_type == REQ_LEFT) || (req_type == REQ_RIGHT))
		|=> req_stall)
		else $error("search transfer did not occupy the scanner");

endmodule

bind phone_number_span_scanner pnss_checker u_pnss_checker (.*);
`default_nettype wire
